// ===== hdl/scheme_atom_lexer_defines.svh =====
// assertion macros shared by the lexer rtl
`ifndef SCHEME_ATOM_LEXER_DEFINES_SVH
`define SCHEME_ATOM_LEXER_DEFINES_SVH

// checked property, ignored while reset is asserted
`define SAL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked property, also during reset
`define SAL_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== hdl/sal_pkg.sv =====
// types and constants of the scheme atom lexer
`default_nettype none

package sal_pkg;

    // result value width and number magnitude width
    localparam int unsigned C_VALUE_BITS = 32;
    localparam int unsigned C_MAG_BITS   = C_VALUE_BITS - 1;

    // byte codes the lexer looks for
    localparam logic [7:0] C_CH_TAB   = 8'h09;
    localparam logic [7:0] C_CH_NL    = 8'h0a;
    localparam logic [7:0] C_CH_CR    = 8'h0d;
    localparam logic [7:0] C_CH_SPACE = 8'h20;
    localparam logic [7:0] C_CH_QUOTE = 8'h22;
    localparam logic [7:0] C_CH_HASH  = 8'h23;
    localparam logic [7:0] C_CH_MINUS = 8'h2d;
    localparam logic [7:0] C_CH_ZERO  = 8'h30;
    localparam logic [7:0] C_CH_NINE  = 8'h39;
    localparam logic [7:0] C_CH_SEMI  = 8'h3b;
    localparam logic [7:0] C_CH_BSL   = 8'h5c;
    localparam logic [7:0] C_CH_F     = 8'h66;
    localparam logic [7:0] C_CH_T     = 8'h74;

    typedef logic [C_VALUE_BITS-1:0] t_value;
    typedef logic [C_MAG_BITS-1:0]   t_mag;

    localparam t_mag C_MAG_MAX = {C_MAG_BITS{1'b1}};

    typedef enum logic [1:0] {
        KIND_NUMBER,
        KIND_BOOL,
        KIND_CHAR,
        KIND_ERROR
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE,
        ERR_NOT_DIGIT,
        ERR_UNKNOWN,
        ERR_SPACE_AFTER_BSL
    } t_err;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_COMMENT,
        MODE_MINUS,
        MODE_NUMBER,
        MODE_HASH,
        MODE_HASH_BSL
    } t_mode;

    // input transaction payload
    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_input;
    } t_in_item;

    // output transaction payload
    typedef struct packed {
        t_kind               kind;
        logic signed [C_VALUE_BITS-1:0] value;
        t_err                error_code;
        logic                saturated;
        logic                last;
    } t_out_item;

    // scanner state carried between bytes
    typedef struct packed {
        t_mode mode;
        t_mag  mag;
        logic  neg;
        logic  clip;
    } t_scan_state;

    // everything one byte produces
    typedef struct packed {
        t_scan_state next;
        logic [1:0]  count;
        t_out_item   res0;
        t_out_item   res1;
    } t_step_out;

endpackage

`default_nettype wire

// ===== hdl/sal_step.sv =====
// next scanner state and up to two results for one input byte
`default_nettype none

module sal_step (
    input  sal_pkg::t_scan_state i_state,
    input  sal_pkg::t_in_item    i_item,
    output sal_pkg::t_step_out   o_step
);

    localparam int unsigned PROD_BITS = sal_pkg::C_MAG_BITS + 4;

    function automatic sal_pkg::t_out_item make_res(
        sal_pkg::t_kind kind, sal_pkg::t_value value, sal_pkg::t_err err, logic sat);
        sal_pkg::t_out_item r;
        r.kind       = kind;
        r.value      = value;
        r.error_code = err;
        r.saturated  = sat;
        r.last       = 1'b0;
        return r;
    endfunction

    logic [7:0]           c;
    logic                 eoi;
    logic                 is_dig;
    logic                 is_sp;
    logic [3:0]           dig;
    sal_pkg::t_mag        dig_mag;
    logic [PROD_BITS-1:0] mag_ext;
    logic [PROD_BITS-1:0] prod;
    logic                 over;
    sal_pkg::t_value      num_abs;
    sal_pkg::t_value      num_val;
    sal_pkg::t_value      char_val;
    sal_pkg::t_value      one_val;
    sal_pkg::t_value      zero_val;
    sal_pkg::t_mode       idle_mode;
    logic                 idle_err;
    logic                 idle_start;
    logic                 use_idle;
    logic                 prim_v;
    sal_pkg::t_out_item   prim;
    sal_pkg::t_out_item   sec;
    logic                 sec_v;
    sal_pkg::t_scan_state nxt;
    sal_pkg::t_out_item   res0;
    sal_pkg::t_out_item   res1;
    logic [1:0]           cnt;

    // byte classes and the decimal accumulate
    always_comb begin
        c        = i_item.ch;
        eoi      = i_item.end_of_input;
        is_dig   = !eoi && (c inside {[sal_pkg::C_CH_ZERO:sal_pkg::C_CH_NINE]});
        is_sp    = (c == sal_pkg::C_CH_SPACE) ||
                   (c inside {[sal_pkg::C_CH_TAB:sal_pkg::C_CH_CR]});
        dig      = 4'(c - sal_pkg::C_CH_ZERO);
        dig_mag  = {{(sal_pkg::C_MAG_BITS-4){1'b0}}, dig};
        mag_ext  = {4'b0000, i_state.mag};
        prod     = (mag_ext << 3) + (mag_ext << 1) + {{(PROD_BITS-4){1'b0}}, dig};
        over     = prod > {4'b0000, sal_pkg::C_MAG_MAX};
        num_abs  = {1'b0, i_state.mag};
        num_val  = i_state.neg ? ({sal_pkg::C_VALUE_BITS{1'b0}} - num_abs) : num_abs;
        char_val = {{(sal_pkg::C_VALUE_BITS-8){1'b0}}, c};
        one_val  = {{(sal_pkg::C_VALUE_BITS-1){1'b0}}, 1'b1};
        zero_val = '0;
    end

    // what a byte does between tokens
    always_comb begin
        idle_mode  = sal_pkg::MODE_IDLE;
        idle_err   = 1'b0;
        idle_start = 1'b0;
        if (eoi || is_sp) begin
            idle_mode = sal_pkg::MODE_IDLE;
        end else if (c == sal_pkg::C_CH_SEMI) begin
            idle_mode = sal_pkg::MODE_COMMENT;
        end else if (is_dig) begin
            idle_mode  = sal_pkg::MODE_NUMBER;
            idle_start = 1'b1;
        end else if (c == sal_pkg::C_CH_MINUS) begin
            idle_mode = sal_pkg::MODE_MINUS;
        end else if (c == sal_pkg::C_CH_HASH) begin
            idle_mode = sal_pkg::MODE_HASH;
        end else begin
            idle_err = 1'b1;
        end
    end

    // scanner transition and first result
    always_comb begin
        nxt      = i_state;
        prim_v   = 1'b0;
        prim     = make_res(sal_pkg::KIND_ERROR, zero_val, sal_pkg::ERR_UNKNOWN, 1'b0);
        use_idle = 1'b0;
        case (i_state.mode)
            sal_pkg::MODE_COMMENT: begin
                if (eoi || c == sal_pkg::C_CH_NL) begin
                    nxt.mode = sal_pkg::MODE_IDLE;
                end
            end
            sal_pkg::MODE_MINUS: begin
                if (is_dig) begin
                    nxt.mode = sal_pkg::MODE_NUMBER;
                    nxt.mag  = dig_mag;
                    nxt.neg  = 1'b1;
                    nxt.clip = 1'b0;
                end else begin
                    prim_v   = 1'b1;
                    use_idle = 1'b1;
                end
            end
            sal_pkg::MODE_NUMBER: begin
                if (is_dig) begin
                    if (over) begin
                        nxt.mag  = sal_pkg::C_MAG_MAX;
                        nxt.clip = 1'b1;
                    end else begin
                        nxt.mag = prod[sal_pkg::C_MAG_BITS-1:0];
                    end
                end else if (eoi || is_sp || c == sal_pkg::C_CH_QUOTE ||
                             c == sal_pkg::C_CH_SEMI) begin
                    prim_v   = 1'b1;
                    prim     = make_res(sal_pkg::KIND_NUMBER, num_val, sal_pkg::ERR_NONE,
                                        i_state.clip);
                    nxt.mag  = '0;
                    nxt.neg  = 1'b0;
                    nxt.clip = 1'b0;
                    use_idle = 1'b1;
                end else begin
                    prim_v   = 1'b1;
                    prim     = make_res(sal_pkg::KIND_ERROR, zero_val,
                                        sal_pkg::ERR_NOT_DIGIT, 1'b0);
                    nxt.mode = sal_pkg::MODE_IDLE;
                    nxt.mag  = '0;
                    nxt.neg  = 1'b0;
                    nxt.clip = 1'b0;
                end
            end
            sal_pkg::MODE_HASH: begin
                nxt.mode = sal_pkg::MODE_IDLE;
                if (!eoi && c == sal_pkg::C_CH_T) begin
                    prim_v = 1'b1;
                    prim   = make_res(sal_pkg::KIND_BOOL, one_val, sal_pkg::ERR_NONE, 1'b0);
                end else if (!eoi && c == sal_pkg::C_CH_F) begin
                    prim_v = 1'b1;
                    prim   = make_res(sal_pkg::KIND_BOOL, zero_val, sal_pkg::ERR_NONE, 1'b0);
                end else if (!eoi && c == sal_pkg::C_CH_BSL) begin
                    nxt.mode = sal_pkg::MODE_HASH_BSL;
                end else begin
                    prim_v   = 1'b1;
                    use_idle = 1'b1;
                end
            end
            sal_pkg::MODE_HASH_BSL: begin
                nxt.mode = sal_pkg::MODE_IDLE;
                prim_v   = 1'b1;
                if (eoi || is_sp) begin
                    prim = make_res(sal_pkg::KIND_ERROR, zero_val,
                                    sal_pkg::ERR_SPACE_AFTER_BSL, 1'b0);
                end else begin
                    prim = make_res(sal_pkg::KIND_CHAR, char_val, sal_pkg::ERR_NONE, 1'b0);
                end
            end
            default: begin
                use_idle = 1'b1;
            end
        endcase

        // byte handled again as the start of a new token
        if (use_idle) begin
            nxt.mode = idle_mode;
            if (idle_start) begin
                nxt.mag  = dig_mag;
                nxt.neg  = 1'b0;
                nxt.clip = 1'b0;
            end
        end
    end

    // pack results into slots and mark the final one
    always_comb begin
        sec_v = use_idle && idle_err;
        sec   = make_res(sal_pkg::KIND_ERROR, zero_val, sal_pkg::ERR_UNKNOWN, 1'b0);
        if (prim_v) begin
            res0 = prim;
            res1 = sec;
            cnt  = sec_v ? 2'd2 : 2'd1;
        end else begin
            res0 = sec;
            res1 = sec;
            cnt  = sec_v ? 2'd1 : 2'd0;
        end
        if (cnt == 2'd2) begin
            res1.last = 1'b1;
        end else begin
            res0.last = 1'b1;
        end
        o_step.next  = nxt;
        o_step.count = cnt;
        o_step.res0  = res0;
        o_step.res1  = res1;
    end

endmodule

`default_nettype wire

// ===== hdl/scheme_atom_lexer.sv =====
// top level of the scheme atom lexer: input register, scanner state, result queue
//
// channel | dir | handshake                | payload
// in      | in  | i_in_valid / o_in_stall  | sal_pkg::t_in_item (ch, end_of_input)
// out     | out | o_out_valid / i_out_stall| sal_pkg::t_out_item (kind .. last)
//
// one byte per cycle enters the input register while the input is not stalled;
// once the queue has room the scanner step runs on the registered byte and
// pushes zero, one or two results into a four-entry result queue; the single
// output port delivers one result per cycle while not stalled, so bytes flow at
// one per cycle while the results keep pace; a two-result byte takes two outputs
// reset (synchronous) clears the scanner to idle and empties the queue
// an output stall fills the queue; the input stalls while a byte waits and the
// queue has fewer than two free entries
`default_nettype none
`include "scheme_atom_lexer_defines.svh"

module scheme_atom_lexer (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  sal_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output sal_pkg::t_out_item  o_out_item
);

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned PTR_BITS    = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

    logic                 r_in_valid;
    logic                 n_in_valid;
    sal_pkg::t_in_item    r_in_item;
    sal_pkg::t_scan_state r_state;
    sal_pkg::t_step_out   step;
    sal_pkg::t_out_item   r_queue [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]  r_wr_ptr;
    logic [PTR_BITS-1:0]  n_wr_ptr;
    logic [PTR_BITS-1:0]  wr_ptr_inc;
    logic [PTR_BITS-1:0]  r_rd_ptr;
    logic [PTR_BITS-1:0]  n_rd_ptr;
    logic [CNT_BITS-1:0]  r_count;
    logic [CNT_BITS-1:0]  n_count;
    logic                 room;
    logic                 fire;
    logic                 in_take;
    logic                 out_take;
    logic [CNT_BITS-1:0]  push_n;

    // scanner step on the registered byte
    sal_step u_step (
        .i_state (r_state),
        .i_item  (r_in_item),
        .o_step  (step)
    );

    // stall and valid outputs from registered state only, plus next pointers and count
    always_comb begin
        room        = r_count <= CNT_BITS'(QUEUE_DEPTH - 2);
        fire        = r_in_valid && room;
        o_in_stall  = r_in_valid && !room;
        in_take     = i_in_valid && !o_in_stall;
        o_out_valid = r_count != '0;
        out_take    = o_out_valid && !i_out_stall;
        o_out_item  = r_queue[r_rd_ptr];
        push_n      = fire ? CNT_BITS'(step.count) : '0;
        wr_ptr_inc  = r_wr_ptr + PTR_BITS'(1);
        n_in_valid  = in_take || (r_in_valid && !fire);
        n_wr_ptr    = r_wr_ptr + PTR_BITS'(push_n);
        n_rd_ptr    = out_take ? (r_rd_ptr + PTR_BITS'(1)) : r_rd_ptr;
        n_count     = r_count + push_n - CNT_BITS'(out_take);
    end

    // control registers and scanner state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_count      <= '0;
            r_state.mode <= sal_pkg::MODE_IDLE;
            r_state.mag  <= '0;
            r_state.neg  <= 1'b0;
            r_state.clip <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
            r_wr_ptr   <= n_wr_ptr;
            r_rd_ptr   <= n_rd_ptr;
            r_count    <= n_count;
            if (fire) begin
                r_state <= step.next;
            end
        end
    end

    // input payload register
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item <= i_in_item;
        end
    end

    // result queue writes
    always_ff @(posedge i_clk) begin
        if (fire && step.count != 2'd0) begin
            r_queue[r_wr_ptr] <= step.res0;
        end
        if (fire && step.count == 2'd2) begin
            r_queue[wr_ptr_inc] <= step.res1;
        end
    end

    `SAL_ASSERT(a_queue_bound, r_count <= CNT_BITS'(QUEUE_DEPTH), "result queue overflow")
    `SAL_ASSERT(a_push_shows, fire && step.count != 2'd0 |=> o_out_valid, "pushed result not offered")
    `SAL_ASSERT(a_clip_max, r_state.clip |-> r_state.mag == sal_pkg::C_MAG_MAX, "clipped magnitude not at maximum")
    `SAL_ASSERT(a_idle_clear, r_state.mode != sal_pkg::MODE_NUMBER |-> (r_state.mag == '0 && !r_state.neg && !r_state.clip), "number state left dirty")
    `SAL_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_out_valid && !o_in_stall, "reset did not empty the lexer")

endmodule

`default_nettype wire
